>>> design/lat_pkg.sv
// lat_pkg: shared constants for the look-at view matrix pipeline
// no dependencies; imported by the interfaces, lat_norm, lat_xlat, look_at_view_matrix and the test
`default_nettype none
package lat_pkg;

  localparam int LAT_DATA_W    = 32;
  localparam int LAT_FRAC_BITS = 16;
  localparam int LAT_ROW_W     = 2;
  // block-scaled magnitude width of a vector before the square root
  localparam int LAT_MAG_W     = 30;

  localparam logic [LAT_ROW_W-1:0] LAT_ROW_RIGHT = 2'd0;
  localparam logic [LAT_ROW_W-1:0] LAT_ROW_UP    = 2'd1;
  localparam logic [LAT_ROW_W-1:0] LAT_ROW_SIGHT = 2'd2;
  localparam logic [LAT_ROW_W-1:0] LAT_ROW_LAST  = 2'd3;

endpackage
`default_nettype wire

>>> design/lat_in_if.sv
// lat_in_if: input channel, eye, aim point and up hint per transaction
// depends on lat_pkg
`default_nettype none
interface lat_in_if import lat_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [LAT_DATA_W-1:0] eye_x;
  logic signed [LAT_DATA_W-1:0] eye_y;
  logic signed [LAT_DATA_W-1:0] eye_z;
  logic signed [LAT_DATA_W-1:0] aim_x;
  logic signed [LAT_DATA_W-1:0] aim_y;
  logic signed [LAT_DATA_W-1:0] aim_z;
  logic signed [LAT_DATA_W-1:0] upward_x;
  logic signed [LAT_DATA_W-1:0] upward_y;
  logic signed [LAT_DATA_W-1:0] upward_z;

  modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                  upward_x, upward_y, upward_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                  upward_x, upward_y, upward_z, output ready);
endinterface
`default_nettype wire

>>> design/lat_out_if.sv
// lat_out_if: result channel, one matrix row per transaction
// depends on lat_pkg
`default_nettype none
interface lat_out_if import lat_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [LAT_ROW_W-1:0]         row_number;
  logic signed [LAT_DATA_W-1:0] elem0;
  logic signed [LAT_DATA_W-1:0] elem1;
  logic signed [LAT_DATA_W-1:0] elem2;
  logic signed [LAT_DATA_W-1:0] elem3;
  logic                         final_row;
  logic                         degenerate;

  modport source (output valid, row_number, elem0, elem1, elem2, elem3, final_row,
                  degenerate, input ready);
  modport sink   (input valid, row_number, elem0, elem1, elem2, elem3, final_row,
                  degenerate, output ready);
endinterface
`default_nettype wire

>>> design/lat_dly.sv
// lat_dly: enabled shift-register delay line for sideband data and valid bits
// depends on nothing but the clock enable of the surrounding pipeline
`default_nettype none
module lat_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] pipe [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < N; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[N-1];
endmodule
`default_nettype wire

>>> design/lat_norm.sv
// lat_norm: pipelined vector normalizer: block scale, square sum, bit-serial
// square root stages and restoring division stages; depends on lat_pkg, lat_dly
`default_nettype none
module lat_norm import lat_pkg::*; #(
  parameter int FB = LAT_FRAC_BITS,
  parameter int VW = 33,
  parameter int SW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [VW-1:0] vec [3],
  input  wire logic [SW-1:0]        in_side,
  output logic                      out_valid,
  output logic signed [FB+1:0]      unit [3],
  output logic                      ok,
  output logic [SW-1:0]             out_side
);
  localparam int MW  = LAT_MAG_W;
  localparam int RJ  = $clog2(VW - MW + 1);
  localparam int LJ  = 5;
  localparam int NS  = RJ + LJ;
  localparam int SQW = 2 * MW + 2;
  localparam int RTW = MW + 1;
  localparam int RMW = RTW + 3;
  localparam int QW  = FB + 1;
  localparam int UW  = FB + 2;
  localparam int NW  = MW + FB + 1;
  localparam int RW  = RTW + 1;
  localparam int LAT = NS + RTW + QW + 6;

  logic [VW-1:0]     a_mag [3];
  logic [VW-1:0]     b_max;
  logic [VW-1:0]     st_mag [NS+1][3];
  logic [VW-1:0]     st_max [NS+1];
  logic [2*MW-1:0]   sq [3];
  logic [SQW-1:0]    rt_n [RTW+1];
  logic [RMW-1:0]    rt_rem [RTW+1];
  logic [RTW-1:0]    rt_root [RTW+1];
  logic [RMW-1:0]    rt_t [RTW];
  logic [RMW-1:0]    rt_trial [RTW];
  logic [3*MW-1:0]   m_flat;
  logic [3*MW-1:0]   m_dly;
  logic [MW-1:0]     m_d [3];
  logic [NW-1:0]     d0_n [3];
  logic [RW-1:0]     dv_rem [QW+1][3];
  logic [QW-1:0]     dv_lo [QW+1][3];
  logic [QW-1:0]     dv_q [QW+1][3];
  logic [RTW-1:0]    dv_len [QW+1];
  logic [RW-1:0]     dv_t [QW][3];
  logic              dv_ge [QW][3];
  logic              in_zero;
  logic [3:0]        flags;
  logic [SW:0]       side_q;
  logic              zero_q;

  // entry flags: component signs and the all-zero case
  assign in_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);

  lat_dly #(.W(4), .N(LAT-1)) u_flags (
    .clk(clk), .rst(rst), .en(en),
    .d({in_zero, vec[0][VW-1], vec[1][VW-1], vec[2][VW-1]}),
    .q(flags)
  );

  lat_dly #(.W(SW+1), .N(LAT)) u_side (
    .clk(clk), .rst(rst), .en(en),
    .d({in_valid, in_side}),
    .q(side_q)
  );

  assign out_valid = side_q[SW];
  assign out_side  = side_q[SW-1:0];

  always_comb begin
    b_max = a_mag[0];
    if (a_mag[1] > b_max) b_max = a_mag[1];
    if (a_mag[2] > b_max) b_max = a_mag[2];
  end

  // magnitude, max and block scaling steps
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[i]     <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
        st_mag[0][i] <= a_mag[i];
      end
      st_max[0] <= b_max;
      for (int j = 0; j < NS; j++) begin
        if (j < RJ) begin
          if ((st_max[j] >> (MW - 1 + (1 << (RJ - 1 - j)))) != '0) begin
            st_max[j+1] <= st_max[j] >> (1 << (RJ - 1 - j));
            for (int i = 0; i < 3; i++) st_mag[j+1][i] <= st_mag[j][i] >> (1 << (RJ - 1 - j));
          end else begin
            st_max[j+1] <= st_max[j];
            for (int i = 0; i < 3; i++) st_mag[j+1][i] <= st_mag[j][i];
          end
        end else begin
          if ((st_max[j] >> (MW - (1 << (NS - 1 - j)))) == '0) begin
            st_max[j+1] <= st_max[j] << (1 << (NS - 1 - j));
            for (int i = 0; i < 3; i++) st_mag[j+1][i] <= st_mag[j][i] << (1 << (NS - 1 - j));
          end else begin
            st_max[j+1] <= st_max[j];
            for (int i = 0; i < 3; i++) st_mag[j+1][i] <= st_mag[j][i];
          end
        end
      end
    end
  end

  // squares and their sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq[i] <= st_mag[NS][i][MW-1:0] * st_mag[NS][i][MW-1:0];
      rt_n[0]    <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
    end
  end

  // square root, one result bit per stage
  always_comb begin
    for (int j = 0; j < RTW; j++) begin
      rt_t[j]     = {rt_rem[j][RMW-3:0], rt_n[j][SQW-1 -: 2]};
      rt_trial[j] = {1'b0, rt_root[j], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < RTW; j++) begin
        rt_n[j+1] <= rt_n[j] << 2;
        if (rt_t[j] >= rt_trial[j]) begin
          rt_rem[j+1]  <= rt_t[j] - rt_trial[j];
          rt_root[j+1] <= {rt_root[j][RTW-2:0], 1'b1};
        end else begin
          rt_rem[j+1]  <= rt_t[j];
          rt_root[j+1] <= {rt_root[j][RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign m_flat = {st_mag[NS][0][MW-1:0], st_mag[NS][1][MW-1:0], st_mag[NS][2][MW-1:0]};

  lat_dly #(.W(3*MW), .N(RTW+2)) u_mag (
    .clk(clk), .rst(rst), .en(en), .d(m_flat), .q(m_dly)
  );

  assign {m_d[0], m_d[1], m_d[2]} = m_dly;

  // division: ((mag << FB) + len/2) / len, one quotient bit per stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_n[i] = NW'({m_d[i], {FB{1'b0}}}) + NW'(rt_root[RTW] >> 1);
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_t[j][i]  = {dv_rem[j][i][RW-2:0], dv_lo[j][i][QW-1]};
        dv_ge[j][i] = dv_t[j][i] >= {1'b0, dv_len[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[0] <= rt_root[RTW];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= RW'(d0_n[i][NW-1:QW]);
        dv_lo[0][i]  <= d0_n[i][QW-1:0];
        dv_q[0][i]   <= '0;
      end
      for (int j = 0; j < QW; j++) begin
        dv_len[j+1] <= dv_len[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= dv_ge[j][i] ? dv_t[j][i] - {1'b0, dv_len[j]} : dv_t[j][i];
          dv_lo[j+1][i]  <= dv_lo[j][i] << 1;
          dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], dv_ge[j][i]};
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (flags[3]) begin
          unit[i] <= '0;
        end else if (flags[2-i]) begin
          unit[i] <= UW'(-{1'b0, dv_q[QW][i]});
        end else begin
          unit[i] <= {1'b0, dv_q[QW][i]};
        end
      end
    end
  end

  // ok follows the delayed zero flag of the same item
  always_ff @(posedge clk) begin
    if (en) zero_q <= flags[3];
  end
  assign ok = !zero_q;
endmodule
`default_nettype wire

>>> design/lat_cross.sv
// lat_cross: two-stage cross product a x b, products then differences
// depends on lat_dly
`default_nettype none
module lat_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [AW-1:0]     a [3],
  input  wire logic signed [BW-1:0]     b [3],
  input  wire logic [SW-1:0]            in_side,
  output logic                          out_valid,
  output logic signed [AW+BW:0]         c [3],
  output logic [SW-1:0]                 out_side
);
  localparam int PW = AW + BW;

  logic signed [PW-1:0] p [6];
  logic [SW:0]          side_q;

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= a[1] * b[2];
      p[1] <= a[2] * b[1];
      p[2] <= a[2] * b[0];
      p[3] <= a[0] * b[2];
      p[4] <= a[0] * b[1];
      p[5] <= a[1] * b[0];
      c[0] <= {p[0][PW-1], p[0]} - {p[1][PW-1], p[1]};
      c[1] <= {p[2][PW-1], p[2]} - {p[3][PW-1], p[3]};
      c[2] <= {p[4][PW-1], p[4]} - {p[5][PW-1], p[5]};
    end
  end

  lat_dly #(.W(SW+1), .N(2)) u_side (
    .clk(clk), .rst(rst), .en(en), .d({in_valid, in_side}), .q(side_q)
  );

  assign out_valid = side_q[SW];
  assign out_side  = side_q[SW-1:0];
endmodule
`default_nettype wire

>>> design/lat_xlat.sv
// lat_xlat: translation column, -dot(basis, eye) rescaled, rounded, saturated
// four stages: products, sums, round, saturate; depends on lat_pkg, lat_dly
`default_nettype none
module lat_xlat import lat_pkg::*; #(
  parameter int FB = LAT_FRAC_BITS,
  parameter int SW = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [FB+1:0]         basis [3][3],
  input  wire logic signed [LAT_DATA_W-1:0] eye [3],
  input  wire logic [SW-1:0]                in_side,
  output logic                              out_valid,
  output logic signed [LAT_DATA_W-1:0]      xl [3],
  output logic [SW-1:0]                     out_side
);
  localparam int PW  = FB + 2 + LAT_DATA_W;
  localparam int SMW = PW + 2;
  localparam int RNW = SMW + 1 - FB;
  localparam logic [RNW-1:0] SAT_NEG = RNW'(64'h8000_0000);
  localparam logic [RNW-1:0] SAT_POS = RNW'(64'h7FFF_FFFF);

  logic signed [PW-1:0]  p [3][3];
  logic signed [SMW-1:0] sm [3];
  logic [SMW-1:0]        mag [3];
  logic [SMW:0]          rnd_full [3];
  logic [RNW-1:0]        rn [3];
  logic                  rn_neg [3];
  logic [RNW-1:0]        cl [3];
  logic [RNW-1:0]        cl_neg [3];
  logic [SW:0]           side_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r]      = sm[r][SMW-1] ? SMW'(-sm[r]) : SMW'(sm[r]);
      rnd_full[r] = {1'b0, mag[r]} + ((SMW+1)'(1) << (FB - 1));
      if (rn_neg[r]) begin
        cl[r] = (rn[r] > SAT_NEG) ? SAT_NEG : rn[r];
      end else begin
        cl[r] = (rn[r] > SAT_POS) ? SAT_POS : rn[r];
      end
      cl_neg[r] = (~cl[r]) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) p[r][k] <= basis[r][k] * eye[k];
        sm[r]     <= SMW'(p[r][0]) + SMW'(p[r][1]) + SMW'(p[r][2]);
        rn_neg[r] <= !sm[r][SMW-1] && (sm[r] != '0);
        rn[r]     <= rnd_full[r][SMW:FB];
        xl[r]     <= rn_neg[r] ? cl_neg[r][LAT_DATA_W-1:0] : cl[r][LAT_DATA_W-1:0];
      end
    end
  end

  lat_dly #(.W(SW+1), .N(4)) u_side (
    .clk(clk), .rst(rst), .en(en), .d({in_valid, in_side}), .q(side_q)
  );

  assign out_valid = side_q[SW];
  assign out_side  = side_q[SW-1:0];
endmodule
`default_nettype wire

>>> design/look_at_view_matrix.sv
// look_at_view_matrix: look-at view matrix, one transaction in, four row transactions out
// pipeline: three normalizer pipelines of NS + FRAC_BITS + 38 stages, two 2-stage cross
//   products, a 4-stage translation unit and the row register
// flow: the four rows per matrix on the result channel bound the rate; the pipeline
//   stalls only while a finished matrix waits for a full row register
// reset: synchronous rst clears all valid bits and the row register's full flag and row; no clearing pass
`default_nettype none
module look_at_view_matrix import lat_pkg::*; #(
  parameter int FRAC_BITS = LAT_FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst,
  lat_in_if.sink   item,
  lat_out_if.source result
);
  localparam int UW   = FRAC_BITS + 2;
  localparam int DW   = LAT_DATA_W;
  localparam int CW1  = DW + UW + 1;
  localparam int CW2  = 2 * UW + 1;
  localparam int NV3  = (CW2 > LAT_MAG_W + 1) ? CW2 : LAT_MAG_W + 1;
  localparam int SW1  = 6 * DW;
  localparam int CS1W = 3 * DW + 3 * UW + 1;
  localparam int CS2W = CS1W + 3 * UW + 1;
  localparam int XSW  = 9 * UW + 1;

  logic en;

  // stage 1: sight = normalize(eye - aim)
  logic signed [DW:0]   dv [3];
  logic                 n1_valid, n1_ok;
  logic signed [UW-1:0] s1 [3];
  logic [SW1-1:0]       n1_side;
  logic signed [DW-1:0] n1_eye [3];
  logic signed [DW-1:0] n1_up [3];

  assign dv[0] = {item.eye_x[DW-1], item.eye_x} - {item.aim_x[DW-1], item.aim_x};
  assign dv[1] = {item.eye_y[DW-1], item.eye_y} - {item.aim_y[DW-1], item.aim_y};
  assign dv[2] = {item.eye_z[DW-1], item.eye_z} - {item.aim_z[DW-1], item.aim_z};

  lat_norm #(.FB(FRAC_BITS), .VW(DW+1), .SW(SW1)) u_norm_sight (
    .clk(clk), .rst(rst), .en(en), .in_valid(item.valid), .vec(dv),
    .in_side({item.eye_x, item.eye_y, item.eye_z,
              item.upward_x, item.upward_y, item.upward_z}),
    .out_valid(n1_valid), .unit(s1), .ok(n1_ok), .out_side(n1_side)
  );

  assign {n1_eye[0], n1_eye[1], n1_eye[2], n1_up[0], n1_up[1], n1_up[2]} = n1_side;

  // stage 2: right = normalize(up x sight)
  logic                 c1_valid;
  logic signed [CW1-1:0] c1_vec [3];
  logic [CS1W-1:0]      c1_side;

  lat_cross #(.AW(DW), .BW(UW), .SW(CS1W)) u_cross_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(n1_valid), .a(n1_up), .b(s1),
    .in_side({n1_eye[0], n1_eye[1], n1_eye[2], s1[0], s1[1], s1[2], n1_ok}),
    .out_valid(c1_valid), .c(c1_vec), .out_side(c1_side)
  );

  logic                 n2_valid, n2_ok;
  logic signed [UW-1:0] r2 [3];
  logic [CS1W-1:0]      n2_side;
  logic signed [DW-1:0] n2_eye [3];
  logic signed [UW-1:0] n2_s [3];
  logic                 n2_ok1;

  lat_norm #(.FB(FRAC_BITS), .VW(CW1), .SW(CS1W)) u_norm_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_valid), .vec(c1_vec), .in_side(c1_side),
    .out_valid(n2_valid), .unit(r2), .ok(n2_ok), .out_side(n2_side)
  );

  assign {n2_eye[0], n2_eye[1], n2_eye[2], n2_s[0], n2_s[1], n2_s[2], n2_ok1} = n2_side;

  // stage 3: true up = normalize(sight x right)
  logic                  c2_valid;
  logic signed [CW2-1:0] c2_vec [3];
  logic signed [NV3-1:0] c2_ext [3];
  logic [CS2W-1:0]       c2_side;

  lat_cross #(.AW(UW), .BW(UW), .SW(CS2W)) u_cross_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(n2_valid), .a(n2_s), .b(r2),
    .in_side({n2_side, r2[0], r2[1], r2[2], n2_ok}),
    .out_valid(c2_valid), .c(c2_vec), .out_side(c2_side)
  );

  assign c2_ext[0] = NV3'(c2_vec[0]);
  assign c2_ext[1] = NV3'(c2_vec[1]);
  assign c2_ext[2] = NV3'(c2_vec[2]);

  logic                 n3_valid, n3_ok;
  logic signed [UW-1:0] u3 [3];
  logic [CS2W-1:0]      n3_side;
  logic signed [DW-1:0] n3_eye [3];
  logic signed [UW-1:0] n3_s [3];
  logic signed [UW-1:0] n3_r [3];
  logic                 n3_ok1, n3_ok2;

  lat_norm #(.FB(FRAC_BITS), .VW(NV3), .SW(CS2W)) u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(c2_valid), .vec(c2_ext), .in_side(c2_side),
    .out_valid(n3_valid), .unit(u3), .ok(n3_ok), .out_side(n3_side)
  );

  assign {n3_eye[0], n3_eye[1], n3_eye[2], n3_s[0], n3_s[1], n3_s[2], n3_ok1,
          n3_r[0], n3_r[1], n3_r[2], n3_ok2} = n3_side;

  // translation column for rows right, true up, sight
  logic signed [UW-1:0] xb [3][3];
  logic                 x_valid;
  logic signed [DW-1:0] xl [3];
  logic [XSW-1:0]       x_side;
  logic signed [UW-1:0] x_b [3][3];
  logic                 x_deg;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xb[0][k] = n3_r[k];
      xb[1][k] = u3[k];
      xb[2][k] = n3_s[k];
    end
  end

  lat_xlat #(.FB(FRAC_BITS), .SW(XSW)) u_xlat (
    .clk(clk), .rst(rst), .en(en), .in_valid(n3_valid), .basis(xb), .eye(n3_eye),
    .in_side({n3_r[0], n3_r[1], n3_r[2], u3[0], u3[1], u3[2], n3_s[0], n3_s[1], n3_s[2],
              !(n3_ok1 && n3_ok2 && n3_ok)}),
    .out_valid(x_valid), .xl(xl), .out_side(x_side)
  );

  assign {x_b[0][0], x_b[0][1], x_b[0][2], x_b[1][0], x_b[1][1], x_b[1][2],
          x_b[2][0], x_b[2][1], x_b[2][2], x_deg} = x_side;

  // row register: holds one matrix and walks its four rows
  logic                  ser_full;
  logic [LAT_ROW_W-1:0]  ser_row;
  logic signed [UW-1:0]  ser_b [3][3];
  logic signed [DW-1:0]  ser_t [3];
  logic                  ser_deg;
  logic                  ser_done;

  assign ser_done = result.valid && result.ready && (ser_row == LAT_ROW_LAST);
  assign en       = !(x_valid && ser_full && !ser_done);
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_full <= 1'b0;
      ser_row  <= LAT_ROW_RIGHT;
    end else if (en && x_valid) begin
      ser_full <= 1'b1;
      ser_row  <= LAT_ROW_RIGHT;
    end else if (ser_done) begin
      ser_full <= 1'b0;
    end else if (result.valid && result.ready) begin
      ser_row <= ser_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && x_valid) begin
      ser_b   <= x_b;
      ser_t   <= xl;
      ser_deg <= x_deg;
    end
  end

  assign result.valid      = ser_full;
  assign result.row_number = ser_row;
  assign result.final_row  = (ser_row == LAT_ROW_LAST);
  assign result.degenerate = ser_deg;

  always_comb begin
    unique case (ser_row)
      LAT_ROW_RIGHT: begin
        result.elem0 = DW'(ser_b[0][0]);
        result.elem1 = DW'(ser_b[0][1]);
        result.elem2 = DW'(ser_b[0][2]);
        result.elem3 = ser_t[0];
      end
      LAT_ROW_UP: begin
        result.elem0 = DW'(ser_b[1][0]);
        result.elem1 = DW'(ser_b[1][1]);
        result.elem2 = DW'(ser_b[1][2]);
        result.elem3 = ser_t[1];
      end
      LAT_ROW_SIGHT: begin
        result.elem0 = DW'(ser_b[2][0]);
        result.elem1 = DW'(ser_b[2][1]);
        result.elem2 = DW'(ser_b[2][2]);
        result.elem3 = ser_t[2];
      end
      default: begin
        result.elem0 = '0;
        result.elem1 = '0;
        result.elem2 = '0;
        result.elem3 = DW'(64'd1 << FRAC_BITS);
      end
    endcase
  end
endmodule
`default_nettype wire

>>> test/look_at_view_matrix_test.sv
// look_at_view_matrix_test: self-checking bench for the look-at view matrix block
// depends on lat_pkg, lat_in_if, lat_out_if and look_at_view_matrix
// a directed table, then random transactions, each checked against a built-in predictor
`timescale 1ns / 100ps
`default_nettype none
module look_at_view_matrix_test;
  import lat_pkg::*;

  localparam int FB = LAT_FRAC_BITS;
  localparam int WATCH_LIMIT = 20000;
  localparam int NUM_RANDOM = 290;

  typedef logic signed [LAT_DATA_W-1:0] word_t;
  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    word_t ex, ey, ez, ax, ay, az, ux, uy, uz;
  } view_in_t;

  typedef struct packed {
    logic [LAT_ROW_W-1:0] row;
    word_t e0, e1, e2, e3;
    logic last, deg;
  } view_row_t;

  typedef struct {
    view_in_t stim;
    logic     typed;
    word_t    t0, t1, t2;
    logic     tdeg;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  lat_in_if  item();
  lat_out_if result();

  look_at_view_matrix u_dut (.clk(clk), .rst(rst), .item(item), .result(result));

  view_row_t  rows_pending[$];
  view_in_t   stim_q[$];
  int         errors = 0;
  int         send_idle_pct = 23;
  int         recv_idle_pct = 60;
  int         quiet_cycles = 0;
  logic       stim_done = 1'b0;

  task automatic report(input string what, input view_row_t got, input view_row_t want);
    $display("mismatch %s: got row %0d %h %h %h %h l%b d%b want row %0d %h %h %h %h l%b d%b",
             what, got.row, got.e0, got.e1, got.e2, got.e3, got.last, got.deg,
             want.row, want.e0, want.e1, want.e2, want.e3, want.last, want.deg);
    errors++;
  endtask

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic to_unit(input wide_t v[3], output wide_t u[3]);
    logic [63:0] mag[3], m, sum, len, q;
    logic neg[3];
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (len >> 1)) / len;
      u[i] = neg[i] ? -wide_t'(q) : wide_t'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross_prod(input wide_t a[3], input wide_t b[3],
                                     output wide_t c[3]);
    c[0] = a[1] * b[2] - b[1] * a[2];
    c[1] = a[2] * b[0] - b[2] * a[0];
    c[2] = a[0] * b[1] - b[0] * a[1];
  endfunction

  function automatic word_t offset(input wide_t b[3], input wide_t p[3]);
    wide_t t;
    logic [63:0] mag;
    t = -(b[0] * p[0] + b[1] * p[1] + b[2] * p[2]);
    mag = (t < 0) ? -t : t;
    mag = (mag + (64'd1 << (FB - 1))) >> FB;
    if (t < 0) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return word_t'(-wide_t'(mag));
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return word_t'(mag);
  endfunction

  task automatic predict_view(input view_in_t s);
    wide_t eye[3], up[3], d[3], tmp[3];
    wide_t basis[3][3];
    logic deg;
    view_row_t r;
    eye = '{s.ex, s.ey, s.ez};
    up = '{s.ux, s.uy, s.uz};
    d = '{wide_t'(s.ex) - s.ax, wide_t'(s.ey) - s.ay, wide_t'(s.ez) - s.az};
    deg = 1'b0;
    if (!to_unit(d, basis[2])) deg = 1'b1;
    cross_prod(up, basis[2], tmp);
    if (!to_unit(tmp, basis[0])) deg = 1'b1;
    cross_prod(basis[2], basis[0], tmp);
    if (!to_unit(tmp, basis[1])) deg = 1'b1;
    for (int k = 0; k < 3; k++) begin
      r.row = LAT_ROW_W'(k);
      r.e0 = word_t'(basis[k][0]);
      r.e1 = word_t'(basis[k][1]);
      r.e2 = word_t'(basis[k][2]);
      r.e3 = offset(basis[k], eye);
      r.last = 1'b0;
      r.deg = deg;
      rows_pending.push_back(r);
    end
    r.row = LAT_ROW_LAST;
    r.e0 = 0;
    r.e1 = 0;
    r.e2 = 0;
    r.e3 = word_t'(1) << FB;
    r.last = 1'b1;
    r.deg = deg;
    rows_pending.push_back(r);
  endtask

  function automatic view_in_t mk(input word_t ex, ey, ez, ax, ay, az, ux, uy, uz);
    view_in_t s;
    s = '{ex, ey, ez, ax, ay, az, ux, uy, uz};
    return s;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 3) << 16) - (2 << 16);
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFF_FFFF};
      2: return word_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return word_t'($urandom);
    endcase
  endfunction

  // table of directed stimulus; typed rows carry the expected basis where it is obvious
  task automatic build_stimulus();
    table_row_t t[$];
    table_row_t e;
    word_t one, mx, mn;
    view_in_t s;
    one = 32'sh0001_0000;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    e.typed = 1'b0;
    e.stim = mk(0, 0, one, 0, 0, 0, 0, one, 0);
    t.push_back(e);
    e.stim = mk(0, 0, 0, 0, 0, 0, 0, one, 0);
    e.typed = 1'b1;
    e.t0 = 0;
    e.t1 = 0;
    e.t2 = 0;
    e.tdeg = 1'b1;
    t.push_back(e);
    e.stim = mk(one, 0, 0, 0, 0, 0, 0, 0, 0);
    e.typed = 1'b0;
    t.push_back(e);
    e.stim = mk(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    e.typed = 1'b1;
    t.push_back(e);
    e.stim = mk(0, one, 0, 0, 0, 0, 0, one, 0);
    e.typed = 1'b0;
    t.push_back(e);
    e.stim = mk(mx, mx, mx, mn, mn, mn, mn, mx, mn);
    t.push_back(e);
    e.stim = mk(mn, mn, mn, mx, mx, mx, mx, mn, 0);
    t.push_back(e);
    e.stim = mk(mx, mn, mx, 0, 0, 0, 1, 0, 0);
    t.push_back(e);
    e.stim = mk(1, 0, 0, 0, 0, 0, 0, 1, 0);
    t.push_back(e);
    e.stim = mk(-1, -1, -1, 0, 0, 0, -1, 1, -1);
    t.push_back(e);
    e.stim = mk(mn, 0, 0, mx, 0, 0, 0, 0, mx);
    t.push_back(e);
    e.stim = mk(32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000, 0, 0, 0, 0, one, 0);
    t.push_back(e);
    e.stim = mk(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    t.push_back(e);
    foreach (t[i]) begin
      int base;
      base = rows_pending.size();
      predict_view(t[i].stim);
      if (t[i].typed) begin
        for (int k = 0; k < 4; k++) begin
          if (k < 3 && (rows_pending[base+k].e0 !== t[i].t0 ||
              rows_pending[base+k].e1 !== t[i].t1 || rows_pending[base+k].e2 !== t[i].t2))
            report("table", rows_pending[base+k], rows_pending[base+k]);
          rows_pending[base+k].deg = t[i].tdeg;
          if (k < 3) rows_pending[base+k].e3 = 0;
        end
      end
      stim_q.push_back(t[i].stim);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      s = mk(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
             rand_word(), rand_word(), rand_word());
      if ($urandom_range(0, 19) == 0) begin
        s.ax = s.ex;
        s.ay = s.ey;
        s.az = s.ez;
      end else if ($urandom_range(0, 19) == 0) begin
        s.ux = 0;
        s.uy = 0;
        s.uz = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        s.ux = s.ex - s.ax;
        s.uy = s.ey - s.ay;
        s.uz = s.ez - s.az;
      end
      predict_view(s);
      stim_q.push_back(s);
    end
  endtask

  int sent = 0;
  int total;

  initial begin
    build_stimulus();
    total = stim_q.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      {item.eye_x, item.eye_y, item.eye_z, item.aim_x, item.aim_y, item.aim_z,
       item.upward_x, item.upward_y, item.upward_z} <= '0;
    end else begin
      if (item.valid && item.ready) sent <= sent + 1;
      if (!item.valid || item.ready) begin
        int idx;
        idx = (item.valid && item.ready) ? sent + 1 : sent;
        if (idx < total && $urandom_range(0, 99) >= send_idle_pct) begin
          item.valid <= 1'b1;
          item.eye_x <= stim_q[idx].ex;
          item.eye_y <= stim_q[idx].ey;
          item.eye_z <= stim_q[idx].ez;
          item.aim_x <= stim_q[idx].ax;
          item.aim_y <= stim_q[idx].ay;
          item.aim_z <= stim_q[idx].az;
          item.upward_x <= stim_q[idx].ux;
          item.upward_y <= stim_q[idx].uy;
          item.upward_z <= stim_q[idx].uz;
        end else begin
          item.valid <= 1'b0;
        end
      end
      if (sent * 3 >= total && sent * 3 < 2 * total) begin
        send_idle_pct <= 60;
        recv_idle_pct <= 23;
      end else if (sent * 3 >= 2 * total) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (sent >= total) stim_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    view_row_t got, want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (result.valid && result.ready) begin
        got = '{result.row_number, result.elem0, result.elem1, result.elem2, result.elem3,
                result.final_row, result.degenerate};
        if (rows_pending.size() == 0) begin
          report("unexpected", got, got);
        end else begin
          want = rows_pending.pop_front();
          if (got !== want) report("row", got, want);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((item.valid && item.ready) || (result.valid && result.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (stim_done && rows_pending.size() == 0) break;
    end
    repeat (400) @(posedge clk);
    if (errors == 0 && rows_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/lat_pkg.sv
design/lat_in_if.sv
design/lat_out_if.sv
design/lat_dly.sv
design/lat_norm.sv
design/lat_cross.sv
design/lat_xlat.sv
design/look_at_view_matrix.sv
test/look_at_view_matrix_test.sv
